>>> rtl/kmpq_pkg.sv
// package: shared types and constants for the keyed min-priority queues
package kmpq_pkg;

   localparam int KEY_SLOTS_DEF   = 16;
   localparam int QUEUE_DEPTH_DEF = 16;
   localparam int VALUE_WIDTH_DEF = 32;
   localparam int KEY_W           = 32;
   localparam int OUT_W           = 32;

   typedef enum logic [1:0] {
      ST_INSERTED = 2'd0,
      ST_POPPED   = 2'd1,
      ST_EMPTY    = 2'd2,
      ST_FULL     = 2'd3
   } status_type;

   typedef enum logic {
      ACT_INSERT = 1'b0,
      ACT_POP    = 1'b1
   } action_type;

   typedef struct packed {
      logic                action;
      logic signed [31:0]  key;
      logic signed [31:0]  value;
   } req_type;

   typedef struct packed {
      logic [1:0]          status;
      logic signed [31:0]  popped_value;
   } rsp_type;

endpackage

>>> rtl/kmpq_front.sv
// front end: key lookup against the slot table, classifies each word into a command
module kmpq_front import kmpq_pkg::*; #(
   parameter int KEY_SLOTS = KEY_SLOTS_DEF,
   parameter int SW        = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_type              req,
   // slot table state, owned by the back end
   input  logic [KEY_SLOTS-1:0] slot_valid,
   input  logic [KEY_SLOTS-1:0][KEY_W-1:0] slot_key,
   // classified command out
   output logic                 cmd_valid,
   input  logic                 cmd_ready,
   output req_type              cmd_req,
   output logic                 cmd_hit,
   output logic                 cmd_free,
   output logic [SW-1:0]        cmd_slot
);

   typedef enum logic [2:0] {
      F_IDLE = 3'b001,
      F_SCAN = 3'b010,
      F_DONE = 3'b100
   } fstate_type;

   fstate_type      state_ff, state_in;
   req_type         req_ff, req_in;
   logic [SW:0]     idx_ff, idx_in;
   logic            hit_ff, hit_in, free_ff, free_in;
   logic [SW-1:0]   hslot_ff, hslot_in, fslot_ff, fslot_in;
   logic [SW-1:0]   idx;

   assign idx       = idx_ff[SW-1:0];
   assign req_ready = (state_ff == F_IDLE);
   assign cmd_valid = (state_ff == F_DONE);
   assign cmd_req   = req_ff;
   assign cmd_hit   = hit_ff;
   assign cmd_free  = free_ff;
   assign cmd_slot  = hit_ff ? hslot_ff : fslot_ff;

   // one slot compared per cycle, lowest match and lowest free slot kept
   always_comb begin
      state_in = state_ff;
      req_in   = req_ff;
      idx_in   = idx_ff;
      hit_in   = hit_ff;
      free_in  = free_ff;
      hslot_in = hslot_ff;
      fslot_in = fslot_ff;
      case (state_ff)
         F_IDLE: begin
            if (req_valid) begin
               req_in   = req;
               idx_in   = '0;
               hit_in   = 1'b0;
               free_in  = 1'b0;
               state_in = F_SCAN;
            end
         end
         F_SCAN: begin
            if (slot_valid[idx] && slot_key[idx] == req_ff.key && !hit_ff) begin
               hit_in   = 1'b1;
               hslot_in = idx;
            end
            if (!slot_valid[idx] && !free_ff) begin
               free_in  = 1'b1;
               fslot_in = idx;
            end
            idx_in = idx_ff + 1'b1;
            if (idx_ff == (SW+1)'(KEY_SLOTS - 1)) state_in = F_DONE;
         end
         F_DONE: begin
            if (cmd_ready) state_in = F_IDLE;
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      req_ff   <= req_in;
      idx_ff   <= idx_in;
      hit_ff   <= hit_in;
      free_ff  <= free_in;
      hslot_ff <= hslot_in;
      fslot_ff <= fslot_in;
   end

endmodule

>>> rtl/kmpq_back.sv
// back end: slot table and sorted entry memory, insert and pop by shifting entries one at a time
module kmpq_back import kmpq_pkg::*; #(
   parameter int KEY_SLOTS   = KEY_SLOTS_DEF,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
   parameter int SW          = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 cmd_valid,
   output logic                 cmd_ready,
   input  req_type              cmd_req,
   input  logic                 cmd_hit,
   input  logic                 cmd_free,
   input  logic [SW-1:0]        cmd_slot,
   output logic [KEY_SLOTS-1:0] slot_valid,
   output logic [KEY_SLOTS-1:0][KEY_W-1:0] slot_key,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_type              rsp
);

   localparam int VW    = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;
   localparam int CW    = $clog2(QUEUE_DEPTH + 1);
   localparam int PW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int DEPTH = KEY_SLOTS * QUEUE_DEPTH;
   localparam int AW    = $clog2(DEPTH);

   typedef enum logic [5:0] {
      B_IDLE  = 6'b000001,
      B_IRD   = 6'b000010,
      B_ICMP  = 6'b000100,
      B_PRD   = 6'b001000,
      B_PMOV  = 6'b010000,
      B_OUT   = 6'b100000
   } bstate_type;

   bstate_type                 state_ff, state_in;
   logic [KEY_SLOTS-1:0]       valid_ff;
   logic [KEY_SLOTS-1:0][KEY_W-1:0] key_ff;
   logic [KEY_SLOTS-1:0][CW-1:0]    cnt_ff;
   logic [VW-1:0]              mem [DEPTH];
   logic [VW-1:0]              rd_ff;
   logic [SW-1:0]              slot_ff;
   logic [VW-1:0]              val_ff;
   logic [CW-1:0]              pos_ff, pos_in;
   logic [CW-1:0]              n_ff;
   logic                       wr_en;
   logic [AW-1:0]              wr_addr, rd_addr;
   logic [VW-1:0]              wr_data;
   logic                       rd_en;
   rsp_type                    out_ff, out_in;
   logic                       outv_ff;
   logic                       upd_ins, upd_pop, open_slot;
   logic                       greater;
   logic [AW-1:0]              base;

   assign slot_valid = valid_ff;
   assign slot_key   = key_ff;
   assign rsp_valid  = outv_ff;
   assign rsp        = out_ff;
   assign cmd_ready  = (state_ff == B_IDLE) && !outv_ff;
   assign base       = AW'(slot_ff) * AW'(QUEUE_DEPTH);
   assign greater    = $signed(rd_ff) > $signed(val_ff);

   // sequencer: insert walks down from the tail, pop walks up from the head
   // slot table is settled when the command is taken, so the next lookup sees it
   always_comb begin
      state_in  = state_ff;
      pos_in    = pos_ff;
      out_in    = out_ff;
      wr_en     = 1'b0;
      wr_addr   = '0;
      wr_data   = val_ff;
      rd_en     = 1'b0;
      rd_addr   = '0;
      upd_ins   = 1'b0;
      upd_pop   = 1'b0;
      open_slot = 1'b0;
      case (state_ff)
         B_IDLE: begin
            if (cmd_valid && !outv_ff) begin
               out_in.popped_value = '0;
               if (cmd_req.action == ACT_INSERT) begin
                  if (!cmd_hit && !cmd_free) begin
                     out_in.status = ST_FULL;
                     state_in      = B_OUT;
                  end else if (cmd_hit && cnt_ff[cmd_slot] >= CW'(QUEUE_DEPTH)) begin
                     out_in.status = ST_FULL;
                     state_in      = B_OUT;
                  end else begin
                     open_slot = !cmd_hit;
                     upd_ins   = 1'b1;
                     pos_in    = cmd_hit ? cnt_ff[cmd_slot] : '0;
                     state_in  = B_IRD;
                  end
               end else begin
                  if (!cmd_hit || cnt_ff[cmd_slot] == '0) begin
                     out_in.status = ST_EMPTY;
                     state_in      = B_OUT;
                  end else begin
                     upd_pop  = 1'b1;
                     pos_in   = '0;
                     state_in = B_PRD;
                  end
               end
            end
         end
         B_IRD: begin
            // read the entry below the hole
            if (pos_ff == '0) begin
               wr_en         = 1'b1;
               wr_addr       = base;
               out_in.status = ST_INSERTED;
               state_in      = B_OUT;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = base + AW'(pos_ff - 1'b1);
               state_in = B_ICMP;
            end
         end
         B_ICMP: begin
            wr_en   = 1'b1;
            wr_addr = base + AW'(pos_ff);
            if (greater) begin
               wr_data  = rd_ff;
               pos_in   = pos_ff - 1'b1;
               state_in = B_IRD;
            end else begin
               out_in.status = ST_INSERTED;
               state_in      = B_OUT;
            end
         end
         B_PRD: begin
            rd_en    = 1'b1;
            rd_addr  = base + AW'(pos_ff);
            state_in = B_PMOV;
         end
         B_PMOV: begin
            if (pos_ff == '0) begin
               out_in.status       = ST_POPPED;
               out_in.popped_value = OUT_W'($signed(rd_ff));
            end else begin
               wr_en   = 1'b1;
               wr_addr = base + AW'(pos_ff - 1'b1);
               wr_data = rd_ff;
            end
            if (pos_ff + 1'b1 >= n_ff) begin
               state_in = B_OUT;
            end else begin
               pos_in   = pos_ff + 1'b1;
               state_in = B_PRD;
            end
         end
         B_OUT: begin
            state_in = B_IDLE;
         end
         default: state_in = B_IDLE;
      endcase
   end

   // entry memory, one write and one registered read a cycle
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rd_ff <= mem[rd_addr];
   end

   // slot table, command latch and output word
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         valid_ff <= '0;
         cnt_ff   <= '0;
         outv_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == B_IDLE && cmd_valid && !outv_ff) begin
            slot_ff <= cmd_slot;
            val_ff  <= VW'(cmd_req.value);
            n_ff    <= cnt_ff[cmd_slot];
         end
         if (open_slot) begin
            valid_ff[cmd_slot] <= 1'b1;
            key_ff[cmd_slot]   <= cmd_req.key;
         end
         if (upd_ins) cnt_ff[cmd_slot] <= (open_slot ? '0 : cnt_ff[cmd_slot]) + CW'(1);
         if (upd_pop) begin
            cnt_ff[cmd_slot] <= cnt_ff[cmd_slot] - CW'(1);
            if (cnt_ff[cmd_slot] == CW'(1)) valid_ff[cmd_slot] <= 1'b0;
         end
         if (state_ff == B_OUT) outv_ff <= 1'b1;
         else if (rsp_ready) outv_ff <= 1'b0;
      end
      pos_ff <= pos_in;
      out_ff <= out_in;
   end

endmodule

>>> rtl/keyed_min_priority_queues.sv
// top level: keyed min-priority queues, front lookup and back shift engine
// Keeps up to KEY_SLOTS keyed queues of up to QUEUE_DEPTH sorted values each.
// Every request word (insert or pop) gives one response word. The front end
// scans the slot table one slot a cycle, then hands a
// classified command to the back end, which updates the slot table as it takes
// the command and then moves entries one at a time through the entry memory,
// each with a registered read and then a write: an insert walks down past the
// larger values, a pop walks up the whole queue, and the back end takes no new
// command while its response waits. The front takes the next request while
// the back end still works on the previous one.
module keyed_min_priority_queues import kmpq_pkg::*; #(
   parameter int KEY_SLOTS   = KEY_SLOTS_DEF,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp
);

   localparam int SW = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;

   logic                 cmd_valid, cmd_ready, cmd_hit, cmd_free;
   req_type              cmd_req;
   logic [SW-1:0]        cmd_slot;
   logic [KEY_SLOTS-1:0] slot_valid;
   logic [KEY_SLOTS-1:0][KEY_W-1:0] slot_key;

   // lookup front end
   kmpq_front #(.KEY_SLOTS(KEY_SLOTS), .SW(SW)) u_front (
      .clock, .reset, .req_valid, .req_ready, .req,
      .slot_valid, .slot_key,
      .cmd_valid, .cmd_ready, .cmd_req, .cmd_hit, .cmd_free, .cmd_slot
   );

   // queue storage back end
   kmpq_back #(
      .KEY_SLOTS(KEY_SLOTS), .QUEUE_DEPTH(QUEUE_DEPTH),
      .VALUE_WIDTH(VALUE_WIDTH), .SW(SW)
   ) u_back (
      .clock, .reset, .cmd_valid, .cmd_ready, .cmd_req, .cmd_hit, .cmd_free,
      .cmd_slot, .slot_valid, .slot_key, .rsp_valid, .rsp_ready, .rsp
   );

endmodule
